### rtl/core/cttf_pkg.sv
// Shared types and constants for the credit-tracked flit FIFO.
`default_nettype none
package cttf_pkg;

	localparam int MaxDepthDef  = 16;
	localparam int FlitWidthDef = 64;
	localparam int DepthCfgW    = 5;
	localparam logic [DepthCfgW-1:0] DepthReset = DepthCfgW'(16);

	typedef enum logic [2:0] {
		OP_ENQ    = 3'd0,
		OP_DEQ    = 3'd1,
		OP_CREDIT = 3'd2,
		OP_FLUSH  = 3'd3,
		OP_STATUS = 3'd4
	} op_t;

	// Per-cycle command broadcast to every slot cell.
	typedef struct packed {
		logic shift;  // every cell takes its neighbor's flit
		logic push;   // the cell at the fill level takes the new flit
	} cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/core/cttf_cell.sv
// One flit slot of the shifting queue; slot 0 is the head.
`default_nettype none
module cttf_cell
	import cttf_pkg::*;
#(
	parameter int IDX        = 0,
	parameter int CNT_W      = 5,
	parameter int FLIT_WIDTH = FlitWidthDef
) (
	input  wire logic                  clk,
	input  wire cell_ctrl_t            ctrl,
	input  wire logic [CNT_W-1:0]      fill,
	input  wire logic [FLIT_WIDTH-1:0] new_flit,
	input  wire logic [FLIT_WIDTH-1:0] from_next,
	output logic      [FLIT_WIDTH-1:0] flit
);

	logic [FLIT_WIDTH-1:0] flit_q;
	logic                  hit;

	assign hit  = (fill == CNT_W'(IDX));
	assign flit = flit_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			flit_q <= from_next;
		end else if (ctrl.push && hit) begin
			flit_q <= new_flit;
		end
	end

endmodule
`default_nettype wire

### rtl/core/cttf_ctrl.sv
// Opcode decode, flit and credit counters, depth register and result flags.
`default_nettype none
module cttf_ctrl
	import cttf_pkg::*;
#(
	parameter int MAX_DEPTH = MaxDepthDef,
	parameter int CNT_W     = $clog2(MAX_DEPTH + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 take,
	input  wire logic [2:0]           opcode,
	input  wire logic                 depth_we,
	input  wire logic [DepthCfgW-1:0] depth_wdata,
	output cell_ctrl_t                cell_ctrl,
	output logic      [CNT_W-1:0]     count,
	output logic      [CNT_W-1:0]     credits,
	output logic                      full,
	output logic                      err,
	output logic                      took,
	output logic                      done
);

	localparam int WideW = (CNT_W > DepthCfgW) ? CNT_W : DepthCfgW;

	logic [DepthCfgW-1:0] depth_q;
	logic [CNT_W-1:0]     count_q, credit_q, count_d, credit_d, eff_depth;
	logic                 full_q, err_q, took_q, done_q, err_d, took_d;
	logic [WideW-1:0]     depth_wide;
	cell_ctrl_t           cc;

	// Zero acts as one, anything above the buffer size saturates.
	always_comb begin
		depth_wide = WideW'(depth_q);
		if (depth_wide == '0) begin
			eff_depth = CNT_W'(1);
		end else if (depth_wide > WideW'(MAX_DEPTH)) begin
			eff_depth = CNT_W'(MAX_DEPTH);
		end else begin
			eff_depth = depth_wide[CNT_W-1:0];
		end
	end

	always_comb begin
		count_d  = count_q;
		credit_d = credit_q;
		err_d    = 1'b0;
		took_d   = 1'b0;
		cc       = '0;
		case (op_t'(opcode))
			OP_ENQ: begin
				if (count_q >= eff_depth) begin
					err_d = 1'b1;
				end else begin
					cc.push = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_DEQ: begin
				if (count_q == '0) begin
					err_d = 1'b1;
				end else begin
					cc.shift = 1'b1;
					took_d   = 1'b1;
					count_d  = count_q - CNT_W'(1);
					// dequeue goes ahead even with no credit outstanding
					if (credit_q == '0) begin
						err_d = 1'b1;
					end else begin
						credit_d = credit_q - CNT_W'(1);
					end
				end
			end
			OP_CREDIT: begin
				if (credit_q >= eff_depth) begin
					err_d = 1'b1;
				end else begin
					credit_d = credit_q + CNT_W'(1);
				end
			end
			OP_FLUSH: begin
				count_d  = '0;
				credit_d = '0;
			end
			OP_STATUS: begin
			end
			default: begin
				err_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= DepthReset;
			count_q  <= '0;
			credit_q <= '0;
			full_q   <= 1'b0;
			err_q    <= 1'b0;
			took_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= take;
			if (depth_we) begin
				depth_q <= depth_wdata;
			end
			if (take) begin
				count_q  <= count_d;
				credit_q <= credit_d;
				full_q   <= (credit_d >= eff_depth);
				err_q    <= err_d;
				took_q   <= took_d;
			end
		end
	end

	assign cell_ctrl = take ? cc : '0;
	assign count     = count_q;
	assign credits   = credit_q;
	assign full      = full_q;
	assign err       = err_q;
	assign took      = took_q;
	assign done      = done_q;

endmodule
`default_nettype wire

### rtl/core/credit_tracked_flit_fifo.sv
// Top level of the credit-tracked flit FIFO: a row of shifting slot cells.
//
//  channel   signals                                   handshake
//  command   start, opcode, flit_data                  start & !busy
//  result    out_flit, last_flit, flit_count,          done, one cycle
//            credits_used, is_full, is_empty, op_error
//  config    depth_limit_we, depth_limit               depth_limit_we
//
// One transaction per cycle: busy stays low, and the result appears with done
// in the cycle after start. The slot cells shift toward the head on a dequeue,
// so the head is always cell 0 and a held tail copy gives the newest flit.
// Reset clears the counters and loads the depth register with 16; the slots
// hold no reset.
// The receiver cannot stall; done lasts exactly one cycle.
`default_nettype none
module credit_tracked_flit_fifo
	import cttf_pkg::*;
#(
	parameter int MAX_DEPTH  = MaxDepthDef,
	parameter int FLIT_WIDTH = FlitWidthDef,
	parameter int CNT_W      = $clog2(MAX_DEPTH + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [2:0]            opcode,
	input  wire logic [FLIT_WIDTH-1:0] flit_data,
	output logic                       done,
	output logic      [FLIT_WIDTH-1:0] out_flit,
	output logic      [FLIT_WIDTH-1:0] last_flit,
	output logic      [CNT_W-1:0]      flit_count,
	output logic      [CNT_W-1:0]      credits_used,
	output logic                       is_full,
	output logic                       is_empty,
	output logic                       op_error,
	input  wire logic                  depth_limit_we,
	input  wire logic [DepthCfgW-1:0]  depth_limit
);

	cell_ctrl_t            cell_ctrl;
	logic [CNT_W-1:0]      count;
	logic                  took, take;
	logic [FLIT_WIDTH-1:0] slot   [MAX_DEPTH];
	logic [FLIT_WIDTH-1:0] link   [MAX_DEPTH];
	logic [FLIT_WIDTH-1:0] tail_q, taken_q;

	assign busy = 1'b0;
	assign take = start & ~busy;

	cttf_ctrl #(
		.MAX_DEPTH (MAX_DEPTH),
		.CNT_W     (CNT_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.opcode      (opcode),
		.depth_we    (depth_limit_we),
		.depth_wdata (depth_limit),
		.cell_ctrl   (cell_ctrl),
		.count       (count),
		.credits     (credits_used),
		.full        (is_full),
		.err         (op_error),
		.took        (took),
		.done        (done)
	);

	for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
		if (i == MAX_DEPTH - 1) begin : g_end
			assign link[i] = '0;
		end else begin : g_mid
			assign link[i] = slot[i+1];
		end
		cttf_cell #(
			.IDX        (i),
			.CNT_W      (CNT_W),
			.FLIT_WIDTH (FLIT_WIDTH)
		) u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl),
			.fill      (count),
			.new_flit  (flit_data),
			.from_next (link[i]),
			.flit      (slot[i])
		);
	end

	// Hold the newest flit and the flit leaving the head.
	always_ff @(posedge clk) begin
		if (cell_ctrl.push) begin
			tail_q <= flit_data;
		end
		if (cell_ctrl.shift) begin
			taken_q <= slot[0];
		end
	end

	always_comb begin
		is_empty   = (count == '0);
		flit_count = count;
		last_flit  = is_empty ? '0 : tail_q;
		if (took) begin
			out_flit = taken_q;
		end else begin
			out_flit = is_empty ? '0 : slot[0];
		end
	end

endmodule
`default_nettype wire

### dv/credit_tracked_flit_fifo_tb.sv
// Self-checking testbench for the credit-tracked flit FIFO: directed table, then random traffic.
`timescale 1ns / 100ps
module credit_tracked_flit_fifo_tb
	import cttf_pkg::*;
();

	localparam int FlitW = FlitWidthDef;
	localparam int CntW = $clog2(MaxDepthDef + 1);
	localparam int WatchLimit = 2000;
	localparam logic [2:0] OpBadLow = 3'd5;
	localparam logic [2:0] OpBadHigh = 3'd7;
	localparam logic [FlitW-1:0] FlitOnes = '1;
	localparam logic [FlitW-1:0] FlitX = 64'hA5A5_5A5A_0F0F_F0F0;
	localparam logic [FlitW-1:0] FlitA = 64'h0123_4567_89AB_CDEF;
	localparam logic [FlitW-1:0] FlitB = 64'hFEDC_BA98_7654_3210;
	localparam logic [FlitW-1:0] FlitC = 64'h8000_0000_0000_0001;

	typedef struct packed {
		logic [FlitW-1:0] out_flit;
		logic [FlitW-1:0] last_flit;
		logic [CntW-1:0]  flit_count;
		logic [CntW-1:0]  credits_used;
		logic             is_full;
		logic             is_empty;
		logic             op_error;
	} buffer_view_t;

	typedef enum logic { ROW_DEPTH, ROW_OP } row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [4:0]       depth_val;
		logic [2:0]       op;
		logic [FlitW-1:0] data;
		bit               typed;
		buffer_view_t     view;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] opcode = OP_STATUS;
	logic [FlitW-1:0] flit_data = '0;
	logic done;
	logic [FlitW-1:0] out_flit;
	logic [FlitW-1:0] last_flit;
	logic [CntW-1:0] flit_count;
	logic [CntW-1:0] credits_used;
	logic is_full;
	logic is_empty;
	logic op_error;
	logic depth_limit_we = 1'b0;
	logic [DepthCfgW-1:0] depth_limit = DepthReset;

	// Predictor state
	logic [FlitW-1:0] held_flits[$];
	int credit_cnt = 0;
	logic [DepthCfgW-1:0] depth_reg = DepthReset;

	buffer_view_t pending_views[$];
	script_row_t script[$];
	bit typed_now = 1'b0;
	buffer_view_t typed_view = '0;
	bit idle_on = 1'b1;
	int mismatches = 0;
	int idle_run = 0;

	credit_tracked_flit_fifo uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.flit_data(flit_data),
		.done(done),
		.out_flit(out_flit),
		.last_flit(last_flit),
		.flit_count(flit_count),
		.credits_used(credits_used),
		.is_full(is_full),
		.is_empty(is_empty),
		.op_error(op_error),
		.depth_limit_we(depth_limit_we),
		.depth_limit(depth_limit)
	);

	always #4 clk = ~clk;

	function automatic int usable_depth();
		int d;
		d = int'(depth_reg);
		if (d == 0) d = 1;
		if (d > MaxDepthDef) d = MaxDepthDef;
		return d;
	endfunction

	// Advance the buffer state by one command and return what the block should show.
	function automatic buffer_view_t buffer_step(logic [2:0] op, logic [FlitW-1:0] data);
		buffer_view_t v;
		int lim;
		logic took;
		logic err;
		logic [FlitW-1:0] taken;
		lim = usable_depth();
		took = 1'b0;
		err = 1'b0;
		taken = '0;
		case (op)
			OP_ENQ: begin
				if (held_flits.size() >= lim) err = 1'b1;
				else held_flits.insert(held_flits.size(), data);
			end
			OP_DEQ: begin
				if (held_flits.size() == 0) begin
					err = 1'b1;
				end else begin
					taken = held_flits[0];
					held_flits.delete(0);
					took = 1'b1;
					// dequeue goes ahead even with no credit out
					if (credit_cnt == 0) err = 1'b1;
					else credit_cnt--;
				end
			end
			OP_CREDIT: begin
				if (credit_cnt >= lim) err = 1'b1;
				else credit_cnt++;
			end
			OP_FLUSH: begin
				held_flits.delete();
				credit_cnt = 0;
			end
			OP_STATUS: ;
			default: err = 1'b1;
		endcase
		v.out_flit = took ? taken : (held_flits.size() != 0 ? held_flits[0] : '0);
		v.last_flit = held_flits.size() != 0 ? held_flits[$] : '0;
		v.flit_count = CntW'(held_flits.size());
		v.credits_used = CntW'(credit_cnt);
		v.is_full = credit_cnt >= lim;
		v.is_empty = held_flits.size() == 0;
		v.op_error = err;
		return v;
	endfunction

	task automatic compare_view(buffer_view_t exp, buffer_view_t got);
		bit bad;
		bad = 1'b0;
		if (got.out_flit !== exp.out_flit) begin
			$error("out_flit: expected %h, got %h", exp.out_flit, got.out_flit);
			bad = 1'b1;
		end
		if (got.last_flit !== exp.last_flit) begin
			$error("last_flit: expected %h, got %h", exp.last_flit, got.last_flit);
			bad = 1'b1;
		end
		if (got.flit_count !== exp.flit_count) begin
			$error("flit_count: expected %0d, got %0d", exp.flit_count, got.flit_count);
			bad = 1'b1;
		end
		if (got.credits_used !== exp.credits_used) begin
			$error("credits_used: expected %0d, got %0d", exp.credits_used, got.credits_used);
			bad = 1'b1;
		end
		if (got.is_full !== exp.is_full) begin
			$error("is_full: expected %b, got %b", exp.is_full, got.is_full);
			bad = 1'b1;
		end
		if (got.is_empty !== exp.is_empty) begin
			$error("is_empty: expected %b, got %b", exp.is_empty, got.is_empty);
			bad = 1'b1;
		end
		if (got.op_error !== exp.op_error) begin
			$error("op_error: expected %b, got %b", exp.op_error, got.op_error);
			bad = 1'b1;
		end
		if (bad) mismatches++;
	endtask

	// Check results, log accepted commands into the predictor, track config writes.
	always @(posedge clk) begin : monitor
		buffer_view_t got;
		buffer_view_t v;
		buffer_view_t exp_v;
		got = '{out_flit, last_flit, flit_count, credits_used, is_full, is_empty, op_error};
		if (done === 1'b1) begin
			if (pending_views.size() == 0) begin
				$error("result with no command outstanding");
				mismatches++;
			end else begin
				exp_v = pending_views[0];
				pending_views.delete(0);
				compare_view(exp_v, got);
			end
		end
		if (arst_n && start && !busy) begin
			v = buffer_step(opcode, flit_data);
			if (typed_now) v = typed_view;
			pending_views.insert(pending_views.size(), v);
		end
		if (arst_n && depth_limit_we) depth_reg = depth_limit;
		if ((start && !busy) || done === 1'b1) idle_run = 0;
		else idle_run++;
		if (idle_run >= WatchLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [2:0] pick_op(bit filling);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) return 3'($urandom_range(OpBadLow, OpBadHigh));
		if (r < 5) return OP_FLUSH;
		if (r < 10) return OP_STATUS;
		if (filling) begin
			if (r < 55) return OP_ENQ;
			if (r < 80) return OP_CREDIT;
			return OP_DEQ;
		end
		if (r < 30) return OP_ENQ;
		if (r < 45) return OP_CREDIT;
		return OP_DEQ;
	endfunction

	function automatic logic [FlitW-1:0] pick_flit();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0) return '0;
		if (r == 1) return FlitOnes;
		return FlitW'({$urandom, $urandom});
	endfunction

	// Present one command starting at a falling edge; return at a falling edge after acceptance.
	task automatic issue(logic [2:0] op, logic [FlitW-1:0] data, bit typed, buffer_view_t view);
		int gap;
		start <= 1'b1;
		opcode <= op;
		flit_data <= data;
		typed_now <= typed;
		typed_view <= view;
		do @(posedge clk); while (busy);
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Write the depth register once every outstanding result is back.
	task automatic set_depth(logic [4:0] val);
		start <= 1'b0;
		do @(negedge clk); while (pending_views.size() != 0);
		repeat (2) @(negedge clk);
		depth_limit_we <= 1'b1;
		depth_limit <= val;
		@(negedge clk);
		depth_limit_we <= 1'b0;
	endtask

	task automatic add_depth(logic [4:0] val);
		script.insert(script.size(), '{ROW_DEPTH, val, OP_STATUS, '0, 1'b0, '0});
	endtask

	task automatic add_op(logic [2:0] op, logic [FlitW-1:0] data);
		script.insert(script.size(), '{ROW_OP, '0, op, data, 1'b0, '0});
	endtask

	task automatic add_chk(logic [2:0] op, logic [FlitW-1:0] data, buffer_view_t view);
		script.insert(script.size(), '{ROW_OP, '0, op, data, 1'b1, view});
	endtask

	initial begin : stimulus
		int phase_depth[11];
		bit filling;
		phase_depth = '{16, 1, 31, 5, 0, 16, 20, 3, 16, 12, 2};

		// depth 16 after reset
		add_chk(OP_STATUS, '0, '{'0, '0, 0, 0, 1'b0, 1'b1, 1'b0});
		add_chk(OP_DEQ, '0, '{'0, '0, 0, 0, 1'b0, 1'b1, 1'b1});
		add_chk(OpBadHigh, FlitOnes, '{'0, '0, 0, 0, 1'b0, 1'b1, 1'b1});
		add_op(OP_ENQ, FlitOnes);
		add_op(OP_ENQ, '0);
		// dequeue with no credit out still removes the head
		add_chk(OP_DEQ, '0, '{FlitOnes, '0, 1, 0, 1'b0, 1'b0, 1'b1});
		add_op(OP_CREDIT, '0);
		add_op(OP_CREDIT, '0);
		add_op(OP_ENQ, FlitX);
		// depth lowered below both counts
		add_depth(5'd1);
		add_chk(OP_ENQ, FlitA, '{'0, FlitX, 2, 2, 1'b1, 1'b0, 1'b1});
		add_chk(OP_CREDIT, '0, '{'0, FlitX, 2, 2, 1'b1, 1'b0, 1'b1});
		add_chk(OP_DEQ, '0, '{'0, FlitX, 1, 1, 1'b1, 1'b0, 1'b0});
		add_chk(OP_FLUSH, FlitOnes, '{'0, '0, 0, 0, 1'b0, 1'b1, 1'b0});
		// zero depth acts as one
		add_depth(5'd0);
		add_op(OP_CREDIT, '0);
		add_chk(OP_CREDIT, '0, '{'0, '0, 0, 1, 1'b1, 1'b1, 1'b1});
		add_op(OP_ENQ, FlitA);
		add_chk(OP_ENQ, FlitB, '{FlitA, FlitA, 1, 1, 1'b1, 1'b0, 1'b1});
		add_op(OP_DEQ, '0);
		// oversized depth saturates
		add_depth(5'd31);
		add_op(OP_CREDIT, '0);
		add_op(OpBadLow, FlitC);
		add_op(OP_ENQ, FlitC);
		add_op(OP_STATUS, '0);
		add_chk(OP_FLUSH, '0, '{'0, '0, 0, 0, 1'b0, 1'b1, 1'b0});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_DEPTH) set_depth(script[i].depth_val);
			else issue(script[i].op, script[i].data, script[i].typed, script[i].view);
		end

		// random traffic: fill and drain bursts at a range of depths
		foreach (phase_depth[p]) begin
			set_depth(p == 10 ? 5'($urandom_range(0, 31)) : 5'(phase_depth[p]));
			idle_on = $urandom_range(0, 3) != 0;
			filling = 1'b1;
			for (int n = 0; n < 100; n++) begin
				if (n % 20 == 0) filling = $urandom_range(0, 1);
				issue(pick_op(filling), pick_flit(), 1'b0, '0);
			end
		end

		start <= 1'b0;
		while (pending_views.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule
